@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, each with a clock and an active-low reset that disables the check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sb2da_pkg.sv @@
// ----------------------------------------------------------------------------
// sb2da_pkg
// Types, character codes and digit helpers for the decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sb2da_pkg;

    // Width of one packed BCD digit.
    localparam int DIGIT_W = 4;

    // ASCII codes used in the output text.
    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_NINE  = 7'd57;
    localparam logic [6:0] CHAR_MINUS = 7'd45;

    // Double dabble correction: digits of five or more get three added.
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_NONE    = 4'd0;

    // Control word sent to every digit cell.
    typedef struct packed {
        logic clear;        // zero the digit before a new conversion
        logic dabble;       // adjust and shift one binary bit in
        logic shift_digit;  // move whole digits one cell toward the top
    } t_cell_ctl;

    // Bit a cell hands to its upper neighbor during a dabble step.
    function automatic logic f_carry(input logic [DIGIT_W-1:0] digit);
        f_carry = (digit >= DIGIT_ADJ_MIN);
    endfunction

endpackage

`default_nettype wire

@@ rtl/sb2da_cell.sv @@
// ----------------------------------------------------------------------------
// sb2da_cell
// One BCD digit of the double dabble chain, which can also pass its digit up.
// ----------------------------------------------------------------------------
`default_nettype none

module sb2da_cell (
    input  wire logic                               i_clk,
    input  wire sb2da_pkg::t_cell_ctl               i_ctl,
    input  wire logic                               i_bit,
    input  wire logic [sb2da_pkg::DIGIT_W-1:0]      i_digit,
    output logic      [sb2da_pkg::DIGIT_W-1:0]      o_digit
);

    logic [sb2da_pkg::DIGIT_W-1:0] r_digit;
    logic [sb2da_pkg::DIGIT_W-1:0] w_adj;
    logic [sb2da_pkg::DIGIT_W-1:0] n_digit;

    // Add three to digits of five or more before the shift.
    assign w_adj = sb2da_pkg::f_carry(r_digit) ? (r_digit + sb2da_pkg::DIGIT_ADJ) : r_digit;

    // Select the next digit from the current operation.
    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = sb2da_pkg::DIGIT_NONE;
        end else if (i_ctl.dabble) begin
            n_digit = {w_adj[sb2da_pkg::DIGIT_W-2:0], i_bit};
        end else if (i_ctl.shift_digit) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule

`default_nettype wire

@@ rtl/signed_binary_to_decimal_ascii.sv @@
// After acceptance the magnitude is shifted bit by bit into the dabble chain, then the
// characters are streamed out; leading zero digits are dropped and a negative value
// gets a minus sign first.
// A new item is taken once the last character is in the output register.
// Reset (synchronous, active low) clears the control state and the output valid.
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text through a chain of BCD
// digit cells, then streams the characters out, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_binary_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [6:0]                   o_character,
    output logic                              o_last_char
);

    // Decimal digits needed for a magnitude of up to 2^(VALUE_BITS-1).
    localparam int NDIG   = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BITS_W = $clog2(VALUE_BITS + 1);
    localparam int CNT_W  = $clog2(NDIG + 1);
    localparam int DW     = sb2da_pkg::DIGIT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag,   n_mag;
    logic                  r_neg,   n_neg;
    logic [BITS_W-1:0]     r_bits,  n_bits;
    logic [CNT_W-1:0]      r_cnt,   n_cnt;
    logic                  r_lead,  n_lead;
    logic                  r_out_valid, n_out_valid;
    logic [6:0]            r_char,  n_char;
    logic                  r_last,  n_last;

    logic [VALUE_BITS-1:0] w_mag_in;
    logic                  w_slot_free;
    logic [DW-1:0]         w_top;
    sb2da_pkg::t_cell_ctl  w_ctl;
    logic [DW-1:0]         w_digit [NDIG];

    // Magnitude of the input, exact for the most negative value.
    assign w_mag_in = i_value[VALUE_BITS-1]
                    ? (~i_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : i_value;

    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_top       = w_digit[NDIG-1];

    // Cell controls for the whole chain.
    always_comb begin
        w_ctl.clear       = (r_state == ST_IDLE) && i_valid;
        w_ctl.dabble      = (r_state == ST_CONV);
        w_ctl.shift_digit = (r_state == ST_EMIT) && w_slot_free && !r_neg;
    end

    // Digit chain: cell 0 is the least significant digit.
    for (genvar k = 0; k < NDIG; k++) begin : g_cell
        logic          w_bit_in;
        logic [DW-1:0] w_digit_in;
        if (k == 0) begin : g_first
            assign w_bit_in   = r_mag[VALUE_BITS-1];
            assign w_digit_in = sb2da_pkg::DIGIT_NONE;
        end else begin : g_rest
            assign w_bit_in   = sb2da_pkg::f_carry(w_digit[k-1]);
            assign w_digit_in = w_digit[k-1];
        end
        sb2da_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_bit   (w_bit_in),
            .i_digit (w_digit_in),
            .o_digit (w_digit[k])
        );
    end

    // Sequencer: load, convert bit by bit, then emit sign and digits.
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_bits      = r_bits;
        n_cnt       = r_cnt;
        n_lead      = r_lead;
        n_out_valid = r_out_valid && i_stall;
        n_char      = r_char;
        n_last      = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_mag   = w_mag_in;
                    n_neg   = i_value[VALUE_BITS-1];
                    n_bits  = BITS_W'(VALUE_BITS);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_mag  = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_bits = r_bits - 1'b1;
                if (r_bits == BITS_W'(1)) begin
                    n_cnt   = CNT_W'(NDIG);
                    n_lead  = 1'b1;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    if (r_neg) begin
                        n_out_valid = 1'b1;
                        n_char      = sb2da_pkg::CHAR_MINUS;
                        n_last      = 1'b0;
                        n_neg       = 1'b0;
                    end else if (r_lead && (w_top == sb2da_pkg::DIGIT_NONE)
                                 && (r_cnt != CNT_W'(1))) begin
                        // Leading zero: drop it.
                        n_cnt = r_cnt - 1'b1;
                    end else begin
                        n_out_valid = 1'b1;
                        n_char      = sb2da_pkg::CHAR_ZERO + {3'b000, w_top};
                        n_last      = (r_cnt == CNT_W'(1));
                        n_cnt       = r_cnt - 1'b1;
                        n_lead      = 1'b0;
                        if (r_cnt == CNT_W'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_neg       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_neg       <= n_neg;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bits <= n_bits;
        r_cnt  <= n_cnt;
        r_lead <= n_lead;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;

endmodule

`default_nettype wire

@@ rtl/sb2da_checker.sv @@
// ----------------------------------------------------------------------------
// sb2da_checker
// Port-level checks on the character stream of the decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sb2da_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [6:0] o_character,
    input wire logic       o_last_char
);

    logic       w_held;
    logic [7:0] w_payload;
    logic       w_char_ok;
    logic       w_minus_last;

    // An offered character that the receiver holds off this cycle.
    assign w_held    = o_valid && i_stall;
    assign w_payload = {o_character, o_last_char};

    // Legal codes are the minus sign and the ten decimal digits.
    assign w_char_ok = !o_valid || (o_character == sb2da_pkg::CHAR_MINUS)
                     || ((o_character >= sb2da_pkg::CHAR_ZERO)
                         && (o_character <= sb2da_pkg::CHAR_NINE));

    assign w_minus_last = o_valid && (o_character == sb2da_pkg::CHAR_MINUS) && o_last_char;

    // A stalled character stays offered.
    `ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, w_held, o_valid, "valid dropped under stall")

    // A stalled character keeps its code and flag.
    `ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, w_held, $stable(w_payload), "payload changed")

    // Only a minus sign or a decimal digit is ever sent.
    `ASSERT_CLK(a_legal_char, i_clk, i_rst_n, w_char_ok, "illegal character")

    // The minus sign never carries the last-character flag.
    `ASSERT_CLK(a_minus_not_last, i_clk, i_rst_n, !w_minus_last, "minus sign ends a run")

endmodule

bind signed_binary_to_decimal_ascii sb2da_checker u_sb2da_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_character (o_character),
    .o_last_char (o_last_char)
);

`default_nettype wire
